FILE: sv/wsts_pkg.sv
// shared types and constants for the weighted sum tree sampler
// depends on nothing; imported by every module of the block
`default_nettype none

package wsts_pkg;

	// input item opcodes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// galois lfsr feedback polynomial
	localparam logic [31:0] LFSR_POLY = 32'hEDB88320;

	// configuration port
	localparam int unsigned PADDR_W = 3;
	localparam logic        REG_LFSR_SEED = 1'b0;

	typedef struct packed {
		logic        opcode;
		logic [9:0]  leaf_index;
		logic [15:0] weight;
	} wsts_item_t;

	typedef struct packed {
		logic [9:0] sampled_index;
		logic       tree_empty;
	} wsts_result_t;

	// controller to datapath and lfsr
	typedef struct packed {
		logic clr_we;
		logic load_item;
		logic leaf_wr;
		logic up_wr;
		logic root_rd;
		logic chk;
		logic mul;
		logic cmp;
		logic out_load;
		logic draw1;
		logic draw2;
	} wsts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic in_sample;
		logic in_range;
		logic up_at_root;
		logic root_zero;
		logic last_level;
		logic out_free;
	} wsts_sts_t;

endpackage

`default_nettype wire

FILE: sv/wsts_lfsr.sv
// 32-bit galois lfsr that hands out random draws in two halves
// depends on wsts_pkg
`default_nettype none

module wsts_lfsr import wsts_pkg::*; #(
	parameter int unsigned RANDOM_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   seed_we,
	input  wire logic [31:0]            seed,
	input  wire logic                   draw1,
	input  wire logic                   draw2,
	output logic      [RANDOM_BITS-1:0] rnd
);

	localparam int unsigned HA = RANDOM_BITS / 2;
	localparam int unsigned HB = RANDOM_BITS - HA;

	logic [31:0]            state_q;
	logic [RANDOM_BITS-1:0] acc_q;
	logic [31:0]            s1, s2;
	logic [HA-1:0]          bits1;
	logic [HB-1:0]          bits2;

	// first half of a draw, first bit ends up most significant
	always_comb begin
		logic [31:0] s;
		s = state_q;
		bits1 = '0;
		for (int k = 0; k < HA; k++) begin
			bits1[HA-1-k] = s[0];
			s = s[0] ? ((s >> 1) ^ LFSR_POLY) : (s >> 1);
		end
		s1 = s;
	end

	// second half
	always_comb begin
		logic [31:0] s;
		s = state_q;
		bits2 = '0;
		for (int k = 0; k < HB; k++) begin
			bits2[HB-1-k] = s[0];
			s = s[0] ? ((s >> 1) ^ LFSR_POLY) : (s >> 1);
		end
		s2 = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= 32'd1;
		end else if (seed_we) begin
			state_q <= (seed == 32'd0) ? 32'd1 : seed;
		end else if (draw1) begin
			state_q <= s1;
		end else if (draw2) begin
			state_q <= s2;
		end
	end

	always_ff @(posedge clk) begin
		if (draw1) begin
			acc_q <= RANDOM_BITS'(bits1);
		end else if (draw2) begin
			acc_q <= (acc_q << HB) | RANDOM_BITS'(bits2);
		end
	end

	assign rnd = acc_q;

endmodule

`default_nettype wire

FILE: sv/wsts_dp.sv
// datapath: sum tree memory, path update adder, descent multiply-compare,
// result register; depends on wsts_pkg
`default_nettype none

module wsts_dp import wsts_pkg::*; #(
	parameter int unsigned LEAVES      = 1024,
	parameter int unsigned LEVELS      = 10,
	parameter int unsigned WEIGHT_BITS = 16,
	parameter int unsigned RANDOM_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire wsts_cmd_t              cmd,
	output wsts_sts_t                   sts,
	input  wire wsts_item_t             item,
	input  wire logic [RANDOM_BITS-1:0] rnd,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output wsts_result_t                result
);

	localparam int unsigned AW    = LEVELS + 1;
	localparam int unsigned DEPTH = 2 ** AW;
	localparam int unsigned SW    = WEIGHT_BITS + LEVELS;
	localparam int unsigned H     = (SW + 1) / 2;
	localparam int unsigned PW    = SW + RANDOM_BITS;

	logic [SW-1:0] mem [DEPTH];
	logic [SW-1:0] rd_q;

	logic [9:0]    idx_q;
	logic [15:0]   wt_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] node_q;
	logic [SW-1:0] sum_q;
	logic [SW-1:0] left_q;
	logic          empty_q;

	logic [H+RANDOM_BITS-1:0]      pl_s1;
	logic [SW-H+RANDOM_BITS-1:0]   ph_s1;

	logic          result_valid_q;
	wsts_result_t  result_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [SW-1:0] wdata;
	logic [AW-1:0] leaf_addr, parent, node_next;
	logic [SW-1:0] up_sum;
	logic [PW-1:0] prod, thr;
	logic          go_left;

	assign leaf_addr = {1'b1, LEVELS'(idx_q)};
	assign parent    = node_q >> 1;
	assign up_sum    = sum_q + rd_q;

	// r * node_sum < left_sum * 2^random_bits
	assign prod      = (PW'(ph_s1) << H) + PW'(pl_s1);
	assign thr       = {left_q, {RANDOM_BITS{1'b0}}};
	assign go_left   = prod < thr;
	assign node_next = {node_q[AW-2:0], ~go_left};

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		if (cmd.leaf_wr) begin
			we    = 1'b1;
			waddr = leaf_addr;
			wdata = SW'(WEIGHT_BITS'(wt_q));
		end else if (cmd.up_wr) begin
			we    = 1'b1;
			waddr = parent;
			wdata = up_sum;
		end else if (cmd.clr_we) begin
			we    = 1'b1;
		end
	end

	always_comb begin
		re    = 1'b1;
		raddr = '0;
		if (cmd.leaf_wr) begin
			raddr = leaf_addr ^ AW'(1);
		end else if (cmd.up_wr) begin
			raddr = parent ^ AW'(1);
		end else if (cmd.root_rd) begin
			raddr = AW'(1);
		end else if (cmd.chk) begin
			raddr = AW'(2);
		end else if (cmd.cmp) begin
			raddr = {node_next[AW-2:0], 1'b0};
		end else begin
			re    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// item, walk and product registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			idx_q <= item.leaf_index;
			wt_q  <= item.weight;
		end
		if (cmd.leaf_wr) begin
			sum_q  <= SW'(WEIGHT_BITS'(wt_q));
			node_q <= leaf_addr;
		end else if (cmd.up_wr) begin
			sum_q  <= up_sum;
			node_q <= parent;
		end else if (cmd.chk) begin
			sum_q   <= rd_q;
			node_q  <= AW'(1);
			empty_q <= (rd_q == '0);
		end else if (cmd.cmp) begin
			sum_q  <= go_left ? left_q : (sum_q - left_q);
			node_q <= node_next;
		end
		if (cmd.mul) begin
			left_q <= rd_q;
			pl_s1  <= sum_q[H-1:0] * rnd;
			ph_s1  <= sum_q[SW-1:H] * rnd;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.sampled_index <= empty_q ? 10'd0 : 10'(node_q[LEVELS-1:0]);
			result_q.tree_empty    <= empty_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign sts.clr_done   = &clr_q;
	assign sts.in_sample  = (item.opcode == OP_SAMPLE);
	assign sts.in_range   = (32'(idx_q) < 32'(LEAVES));
	assign sts.up_at_root = (parent == AW'(1));
	assign sts.root_zero  = (rd_q == '0);
	assign sts.last_level = node_q[LEVELS-1];
	assign sts.out_free   = !result_valid_q || result_ready;

endmodule

`default_nettype wire

FILE: sv/wsts_ctrl.sv
// controller state machine for the sum tree sampler
// depends on wsts_pkg
`default_nettype none

module wsts_ctrl import wsts_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire wsts_sts_t sts,
	output wsts_cmd_t      cmd
);

	typedef enum logic [9:0] {
		S_CLR   = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_ULEAF = 10'b0000000100,
		S_UUP   = 10'b0000001000,
		S_ROOT  = 10'b0000010000,
		S_CHK   = 10'b0000100000,
		S_PRE   = 10'b0001000000,
		S_MUL   = 10'b0010000000,
		S_CMP   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d = sts.in_sample ? S_ROOT : S_ULEAF;
				end
			end
			S_ULEAF: begin
				if (sts.in_range) begin
					cmd.leaf_wr = 1'b1;
					state_d = S_UUP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_UUP: begin
				cmd.up_wr = 1'b1;
				if (sts.up_at_root) begin
					state_d = S_IDLE;
				end
			end
			S_ROOT: begin
				cmd.root_rd = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				if (sts.root_zero) begin
					state_d = S_OUT;
				end else begin
					cmd.draw1 = 1'b1;
					state_d = S_PRE;
				end
			end
			S_PRE: begin
				cmd.draw2 = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				cmd.draw1 = !sts.last_level;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				if (sts.last_level) begin
					state_d = S_OUT;
				end else begin
					cmd.draw2 = 1'b1;
					state_d = S_MUL;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/weighted_sum_tree_sampler_top.sv
// weighted sum tree sampler: an in-range write sets its leaf, then its path up
// to the root before ready returns; a sample item reads the root and, unless it
// is zero, descends level by level into the result register before ready
// returns, later while a result waits for result_ready. one memory read and one
// multiply-compare per level set the pace. reset clears control state, then
// sweeps the tree memory with zeros before the first item; lfsr seed resets to 1
`default_nettype none

module weighted_sum_tree_sampler_top import wsts_pkg::*; #(
	parameter int unsigned LEAVES      = 1024,
	parameter int unsigned WEIGHT_BITS = 16,
	parameter int unsigned RANDOM_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// item channel
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire wsts_item_t         item,
	// result channel
	output logic                    result_valid,
	input  wire logic               result_ready,
	output wsts_result_t            result,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	// tree depth; leaves are padded up to 2^LEVELS
	localparam int unsigned LEVELS = $clog2(LEAVES);

	wsts_cmd_t              cmd;
	wsts_sts_t              sts;
	logic [RANDOM_BITS-1:0] rnd;
	logic [31:0]            seed_q;
	logic                   seed_sel;
	logic                   seed_we;

	// register decode on the word address, one register at word zero
	assign seed_sel = (paddr[2] == REG_LFSR_SEED);
	assign seed_we  = psel && penable && pwrite && seed_sel;
	assign pready   = 1'b1;
	assign prdata   = seed_sel ? seed_q : 32'd0;

	// seed as written; the lfsr itself replaces a zero seed by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd1;
		end else if (seed_we) begin
			seed_q <= pwdata;
		end
	end

	// sequencer: clear sweep, leaf write plus path update, level by level descent
	wsts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// tree memory, adder, split multiplier and compare, result register
	wsts_dp #(
		.LEAVES      (LEAVES),
		.LEVELS      (LEVELS),
		.WEIGHT_BITS (WEIGHT_BITS),
		.RANDOM_BITS (RANDOM_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.rnd          (rnd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// random draw for the next level is built while the current one compares
	wsts_lfsr #(
		.RANDOM_BITS (RANDOM_BITS)
	) u_lfsr (
		.clk     (clk),
		.arst_n  (arst_n),
		.seed_we (seed_we),
		.seed    (pwdata),
		.draw1   (cmd.draw1),
		.draw2   (cmd.draw2),
		.rnd     (rnd)
	);

endmodule

`default_nettype wire

FILE: tb/wsts_sample_checker.sv
// checker for the weighted sum tree sampler: mirrors the sum tree and the lfsr,
// predicts each sample result and compares it with what the block returns
// depends on wsts_pkg; instantiated beside the block by the testbench top
module wsts_sample_checker import wsts_pkg::*; #(
	parameter int unsigned LEAVES      = 1024,
	parameter int unsigned WEIGHT_BITS = 16,
	parameter int unsigned RANDOM_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_ready,
	input  wsts_item_t         item,
	input  logic               result_valid,
	input  logic               result_ready,
	input  wsts_result_t       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 err_count,
	output int                 pending,
	output int                 empty_seen
);

	localparam int unsigned PAD = 1 << $clog2(LEAVES);
	localparam logic [PADDR_W-1:0] SEED_ADDR = PADDR_W'(4 * REG_LFSR_SEED);

	longint unsigned tree_sum [1:2*PAD-1];
	logic [31:0]     lfsr_q;
	wsts_result_t    expected_picks [$];
	int              errs;
	int              empties;

	function automatic longint unsigned draw_random();
		longint unsigned r;
		logic            b;
		r = 0;
		for (int k = 0; k < RANDOM_BITS; k++) begin
			b = lfsr_q[0];
			lfsr_q = lfsr_q >> 1;
			if (b)
				lfsr_q = lfsr_q ^ LFSR_POLY;
			r = (r << 1) | longint'(b);
		end
		return r;
	endfunction

	function automatic void write_leaf(input logic [9:0] idx, input logic [15:0] w);
		int unsigned n;
		if (idx >= LEAVES)
			return;
		n = PAD + idx;
		tree_sum[n] = longint'(w) & ((64'd1 << WEIGHT_BITS) - 64'd1);
		n = n >> 1;
		while (n >= 1) begin
			tree_sum[n] = tree_sum[2*n] + tree_sum[2*n+1];
			n = n >> 1;
		end
	endfunction

	function automatic wsts_result_t pick_leaf();
		wsts_result_t    res;
		int unsigned     n;
		longint unsigned r;
		res = '0;
		if (tree_sum[1] == 0) begin
			res.tree_empty = 1'b1;
			return res;
		end
		n = 1;
		while (n < PAD) begin
			r = draw_random();
			if (r * tree_sum[n] < (tree_sum[2*n] << RANDOM_BITS))
				n = 2 * n;
			else
				n = 2 * n + 1;
		end
		res.sampled_index = 10'(n - PAD);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		wsts_result_t want;
		if (!arst_n) begin
			for (int n = 1; n < 2 * PAD; n++)
				tree_sum[n] = 0;
			lfsr_q = 32'd1;
			expected_picks.delete();
			errs = 0;
			empties = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_picks.size() == 0) begin
					$error("result with nothing expected: sampled_index %0d tree_empty %0d",
						result.sampled_index, result.tree_empty);
					errs++;
				end else begin
					want = expected_picks.pop_front();
					if (result.sampled_index !== want.sampled_index) begin
						$error("sampled_index: expected %0d, got %0d",
							want.sampled_index, result.sampled_index);
						errs++;
					end
					if (result.tree_empty !== want.tree_empty) begin
						$error("tree_empty: expected %0d, got %0d",
							want.tree_empty, result.tree_empty);
						errs++;
					end
					if (want.tree_empty)
						empties++;
				end
			end
			// zero seed loads one
			if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
				lfsr_q = (pwdata == 32'd0) ? 32'd1 : pwdata;
			if (item_valid && item_ready) begin
				if (item.opcode == OP_WRITE)
					write_leaf(item.leaf_index, item.weight);
				else
					expected_picks.push_back(pick_leaf());
			end
		end
		err_count  <= errs;
		pending    <= expected_picks.size();
		empty_seen <= empties;
	end

endmodule

FILE: tb/tb_weighted_sum_tree_sampler_top.sv
// testbench top for the weighted sum tree sampler: drives items, seed writes and
// result backpressure, and gives the verdict from the checker's failure count
// depends on wsts_pkg, weighted_sum_tree_sampler_top and wsts_sample_checker
module tb_weighted_sum_tree_sampler_top;
	import wsts_pkg::*;

	localparam int unsigned LEAVES      = 1024;
	localparam int unsigned WEIGHT_BITS = 16;
	localparam int unsigned RANDOM_BITS = 16;

	// time for a trailing sample or write to finish; leave margin on top
	localparam int unsigned SETTLE_CYCLES = 40;
	// cycles with no handshake at all before the run is declared hung;
	// covers the clearing sweep after reset many times over
	localparam int unsigned STALL_LIMIT = 20000;

	localparam logic [PADDR_W-1:0] SEED_ADDR  = PADDR_W'(4 * REG_LFSR_SEED);
	// next register slot, not implemented, writes there must do nothing
	localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	wsts_item_t         item;
	logic               result_valid;
	logic               result_ready;
	wsts_result_t       result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int err_count;
	int pending;
	int empty_seen;

	// random idle bursts on both channels; cleared for the last phase
	bit idle_on = 1'b1;

	int n_writes;
	int n_samples;
	int n_seeds;
	int quiet_cycles;

	weighted_sum_tree_sampler_top #(
		.LEAVES      (LEAVES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.RANDOM_BITS (RANDOM_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	wsts_sample_checker #(
		.LEAVES      (LEAVES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.RANDOM_BITS (RANDOM_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.err_count    (err_count),
		.pending      (pending),
		.empty_seen   (empty_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any accepted item, result or register access resets the count
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
					(psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// result backpressure: random stall bursts, one assignment per edge
	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	// valid stays high across back-to-back items; it only drops for a gap
	task automatic send_item(input wsts_item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		if (it.opcode == OP_WRITE)
			n_writes++;
		else
			n_samples++;
	endtask

	// setup cycle then access cycle; the extra edge keeps calls from colliding
	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, let every expected result come back, then let a trailing
	// leaf write finish its climb to the root before anything else happens
	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic wsts_item_t leaf_write(input logic [9:0] idx, input logic [15:0] w);
		wsts_item_t it;
		it.opcode     = OP_WRITE;
		it.leaf_index = idx;
		it.weight     = w;
		return it;
	endfunction

	// sample items carry junk in the ignored fields
	function automatic wsts_item_t draw_item(input bit ones);
		wsts_item_t it;
		it        = ones ? '1 : '0;
		it.opcode = OP_SAMPLE;
		return it;
	endfunction

	// half the leaf writes land in a small window so the tree keeps sparse
	// subtrees and zero-sum siblings to descend past
	function automatic wsts_item_t rand_item(input int unsigned hot_base);
		wsts_item_t  it;
		int unsigned pick;
		it.opcode = ($urandom_range(0, 99) < 40) ? OP_SAMPLE : OP_WRITE;
		if ($urandom_range(0, 1) == 0)
			it.leaf_index = 10'($urandom_range(0, LEAVES - 1));
		else
			it.leaf_index = 10'(hot_base + $urandom_range(0, 7));
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1: begin
				it.weight = '0;
			end
			2: begin
				it.weight = '1;
			end
			3, 4: begin
				it.weight = 16'($urandom_range(1, 15));
			end
			default: begin
				it.weight = 16'($urandom());
			end
		endcase
		return it;
	endfunction

	task automatic run_random(input int count, input int unsigned hot_base);
		for (int k = 0; k < count; k++)
			send_item(rand_item(hot_base));
	endtask

	task automatic run_directed();
		// empty tree right after the clearing sweep
		send_item(draw_item(1'b1));
		send_item(leaf_write(10'd0, 16'h0000));
		send_item(draw_item(1'b0));
		// a single heavy leaf at the far right, then both ends equal
		send_item(leaf_write(10'd1023, 16'hFFFF));
		send_item(draw_item(1'b1));
		send_item(leaf_write(10'd0, 16'hFFFF));
		send_item(draw_item(1'b0));
		send_item(draw_item(1'b1));
		send_item(draw_item(1'b0));
		// zero weight leaf must never be picked
		send_item(leaf_write(10'd1023, 16'h0000));
		send_item(draw_item(1'b1));
		// lightest weights on either side of the root split
		send_item(leaf_write(10'd511, 16'h0001));
		send_item(leaf_write(10'd512, 16'h0001));
		send_item(draw_item(1'b0));
		send_item(draw_item(1'b1));
		// clear back to an empty tree
		send_item(leaf_write(10'd0, 16'h0000));
		send_item(leaf_write(10'd511, 16'h0000));
		send_item(leaf_write(10'd512, 16'h0000));
		send_item(draw_item(1'b0));
		// alternating bit patterns in index and weight
		send_item(leaf_write(10'd341, 16'h5555));
		send_item(leaf_write(10'd682, 16'hAAAA));
		send_item(draw_item(1'b1));
		send_item(draw_item(1'b0));
	endtask

	initial begin
		logic [31:0] seed;
		int unsigned hot_base;

		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		n_writes  = 0;
		n_samples = 0;
		n_seeds   = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// first phase runs on the reset seed
		run_directed();

		for (int ph = 0; ph < 6; ph++) begin
			// seed changes only while the block is idle
			wait_idle();
			if (ph == 5)
				idle_on = 1'b0;
			reg_write(SPARE_ADDR, $urandom());
			case (ph)
				0: begin
					seed = 32'h0000_0000;   // falls back to one
				end
				1: begin
					seed = 32'hFFFF_FFFF;
				end
				2: begin
					seed = 32'h0000_0001;
				end
				3: begin
					seed = 32'h8000_0000;
				end
				default: begin
					seed = $urandom();
				end
			endcase
			reg_write(SEED_ADDR, seed);
			n_seeds++;
			hot_base = $urandom_range(0, LEAVES - 8);
			if (ph == 2) begin
				// sender holds off mid-phase until every result is back
				run_random(50, hot_base);
				wait_idle();
				run_random(50, hot_base);
			end else begin
				run_random(100, hot_base);
			end
		end

		wait_idle();

		$display("ran %0d leaf writes and %0d samples (%0d on an empty tree) over %0d seed loads",
			n_writes, n_samples, empty_seen, n_seeds);
		if (err_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
